FILE: sv/sapq_pkg.sv
// shared types and constants of the sorted array priority queue
package sapq_pkg;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned S_DATA_W = 32;
    localparam int unsigned M_DATA_W = 40;

    localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

    typedef logic [CMD_W-1:0]          t_cmd;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [STATUS_W-1:0]       t_status;
    typedef logic [COUNT_W-1:0]        t_count;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SET_OVF,
        OP_SET_EMPTY,
        OP_ENQ_READ,
        OP_ENQ_SHIFT,
        OP_ENQ_PLACE,
        OP_DEQ_HEAD,
        OP_DEQ_DATA,
        OP_DEQ_SHIFT,
        OP_DEQ_POP,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        logic is_enq;
        logic is_deq;
        logic is_peek;
        logic full;
        logic empty;
        logic idx_zero;
        logic idx_one;
        logic gt;
        logic deq_done;
        logic shift_last;
        logic out_free;
    } t_dp_status;

endpackage

FILE: sv/sorted_array_priority_queue_core.sv
// top level of the sorted array min priority queue
// Bounded min priority queue of CAPACITY signed 32-bit entries kept in ascending
// order in a single-port-write RAM. One item is worked on at a time; the RAM is
// walked one entry per cycle. An enqueue shifts each stored entry greater than the
// value up by one and places the value behind them; a dequeue reads the head and
// shifts the remaining entries down; a peek reads the head only. The input is ready
// for the next item in the cycle after the result is loaded into the output
// register, which holds it until it is taken.
module sorted_array_priority_queue_core #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // value[31:0]
    input  logic [sapq_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    // cmd[1:0]
    input  logic [sapq_pkg::CMD_W-1:0]    i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // data[31:0], count[36:32], zero[39:37]
    output logic [sapq_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    // status[1:0]
    output logic [sapq_pkg::STATUS_W-1:0] o_m_axis_tuser
);
    import sapq_pkg::*;

    t_dp_op     w_op;
    t_dp_status w_status;
    t_status    w_res_status;
    t_value     w_res_data;
    t_count     w_res_count;

    sapq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_status   (w_status),
        .o_op       (w_op)
    );

    sapq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_op),
        .i_cmd        (i_s_axis_tuser),
        .i_value      (i_s_axis_tdata),
        .i_m_tready   (i_m_axis_tready),
        .o_status     (w_status),
        .o_m_tvalid   (o_m_axis_tvalid),
        .o_res_status (w_res_status),
        .o_res_data   (w_res_data),
        .o_res_count  (w_res_count)
    );

    assign o_m_axis_tdata = {
        {(M_DATA_W - VALUE_W - COUNT_W){1'b0}}, w_res_count, w_res_data
    };
    assign o_m_axis_tuser = w_res_status;

endmodule

FILE: sv/sapq_ram.sv
// generic single write port ram with registered read
module sapq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/sapq_datapath.sv
// datapath: entry ram, walk index, occupancy and result register
module sapq_datapath #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sapq_pkg::t_dp_op        i_op,
    input  sapq_pkg::t_cmd          i_cmd,
    input  sapq_pkg::t_value        i_value,
    input  logic                    i_m_tready,
    output sapq_pkg::t_dp_status    o_status,
    output logic                    o_m_tvalid,
    output sapq_pkg::t_status       o_res_status,
    output sapq_pkg::t_value        o_res_data,
    output sapq_pkg::t_count        o_res_count
);
    import sapq_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned OW = $clog2(CAPACITY + 1);

    logic [OW-1:0] r_occ;
    logic [OW-1:0] r_idx;
    t_cmd          r_cmd;
    t_value        r_val;
    t_status       r_status;
    t_value        r_data;
    logic          r_out_valid;
    t_status       r_out_status;
    t_value        r_out_data;
    t_count        r_out_count;

    logic [OW-1:0] w_idx_m1;
    logic [OW-1:0] w_idx_m2;
    logic [OW-1:0] w_idx_p1;

    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_value        w_wr_data;
    logic [AW-1:0] w_rd_addr;
    t_value        w_rd_data;

    assign w_idx_m1 = r_idx - OW'(1);
    assign w_idx_m2 = r_idx - OW'(2);
    assign w_idx_p1 = r_idx + OW'(1);

    sapq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_idx[AW-1:0];
        w_wr_data = r_val;
        w_rd_addr = '0;
        unique case (i_op)
            OP_ENQ_READ: begin
                w_rd_addr = w_idx_m1[AW-1:0];
            end
            OP_ENQ_SHIFT: begin
                w_wr_en   = 1'b1;
                w_wr_data = w_rd_data;
                w_rd_addr = w_idx_m2[AW-1:0];
            end
            OP_ENQ_PLACE: begin
                w_wr_en = 1'b1;
            end
            OP_DEQ_DATA: begin
                w_rd_addr = r_idx[AW-1:0];
            end
            OP_DEQ_SHIFT: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_idx_m1[AW-1:0];
                w_wr_data = w_rd_data;
                w_rd_addr = w_idx_p1[AW-1:0];
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_op == OP_ENQ_PLACE) begin
                r_occ <= r_occ + OW'(1);
            end else if (i_op == OP_DEQ_POP) begin
                r_occ <= r_occ - OW'(1);
            end
            if (i_op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_cmd    <= i_cmd;
                r_val    <= i_value;
                r_idx    <= r_occ;
                r_status <= ST_OK;
                r_data   <= '0;
            end
            OP_SET_OVF:   r_status <= ST_OVERFLOW;
            OP_SET_EMPTY: r_status <= ST_EMPTY;
            OP_ENQ_SHIFT: r_idx    <= w_idx_m1;
            OP_DEQ_HEAD:  r_idx    <= OW'(1);
            OP_DEQ_DATA:  r_data   <= w_rd_data;
            OP_DEQ_SHIFT: r_idx    <= w_idx_p1;
            OP_OUT: begin
                r_out_status <= r_status;
                r_out_data   <= r_data;
                r_out_count  <= COUNT_W'(r_occ);
            end
            default: ;
        endcase
    end

    always_comb begin
        o_status.is_enq     = (r_cmd == CMD_ENQ);
        o_status.is_deq     = (r_cmd == CMD_DEQ);
        o_status.is_peek    = (r_cmd == CMD_PEEK);
        o_status.full       = (r_occ == OW'(CAPACITY));
        o_status.empty      = (r_occ == '0);
        o_status.idx_zero   = (r_idx == '0);
        o_status.idx_one    = (r_idx == OW'(1));
        o_status.gt         = (w_rd_data > r_val);
        o_status.deq_done   = (r_idx >= r_occ);
        o_status.shift_last = (w_idx_p1 >= r_occ);
        o_status.out_free   = !r_out_valid || i_m_tready;
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_res_status = r_out_status;
    assign o_res_data   = r_out_data;
    assign o_res_count  = r_out_count;

endmodule

FILE: sv/sapq_ctrl.sv
// controller: sequences enqueue walks, dequeue shifts and result handoff
module sapq_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  sapq_pkg::t_dp_status i_status,
    output sapq_pkg::t_dp_op     o_op
);
    import sapq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_DECIDE    = 8'b0000_0010,
        S_ENQ_WALK  = 8'b0000_0100,
        S_ENQ_LAST  = 8'b0000_1000,
        S_DEQ_DATA  = 8'b0001_0000,
        S_DEQ_SHIFT = 8'b0010_0000,
        S_DEQ_POP   = 8'b0100_0000,
        S_FINISH    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && i_rst_n) begin
                    o_op    = OP_LOAD;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.is_enq) begin
                    if (i_status.full) begin
                        o_op    = OP_SET_OVF;
                        n_state = S_FINISH;
                    end else if (i_status.idx_zero) begin
                        o_op    = OP_ENQ_PLACE;
                        n_state = S_FINISH;
                    end else begin
                        o_op    = OP_ENQ_READ;
                        n_state = S_ENQ_WALK;
                    end
                end else if (i_status.is_deq || i_status.is_peek) begin
                    if (i_status.empty) begin
                        o_op    = OP_SET_EMPTY;
                        n_state = S_FINISH;
                    end else begin
                        o_op    = OP_DEQ_HEAD;
                        n_state = S_DEQ_DATA;
                    end
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_ENQ_WALK: begin
                if (i_status.gt) begin
                    o_op = OP_ENQ_SHIFT;
                    if (i_status.idx_one) begin
                        n_state = S_ENQ_LAST;
                    end
                end else begin
                    o_op    = OP_ENQ_PLACE;
                    n_state = S_FINISH;
                end
            end
            S_ENQ_LAST: begin
                o_op    = OP_ENQ_PLACE;
                n_state = S_FINISH;
            end
            S_DEQ_DATA: begin
                o_op = OP_DEQ_DATA;
                if (i_status.is_peek) begin
                    n_state = S_FINISH;
                end else if (i_status.deq_done) begin
                    n_state = S_DEQ_POP;
                end else begin
                    n_state = S_DEQ_SHIFT;
                end
            end
            S_DEQ_SHIFT: begin
                o_op = OP_DEQ_SHIFT;
                if (i_status.shift_last) begin
                    n_state = S_DEQ_POP;
                end
            end
            S_DEQ_POP: begin
                o_op    = OP_DEQ_POP;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE) && i_rst_n;

endmodule

FILE: tb/sv/tb_sorted_array_priority_queue_core.sv
// self-checking testbench of the sorted array min priority queue core
`timescale 1ns / 100ps

module tb_sorted_array_priority_queue_core;
    import sapq_pkg::*;

    localparam int unsigned CAPACITY    = 16;
    localparam int unsigned RAND_ITEMS  = 1200;
    localparam int unsigned DIR_N       = 24;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN       = CAPACITY + 8;
    localparam longint      LIMIT       = 600000;
    localparam t_cmd        CMD_UNUSED  = 2'd3;

    typedef struct packed {
        t_status status;
        t_value  data;
        t_count  count;
    } t_outcome;

    typedef struct packed {
        t_cmd     cmd;
        t_value   value;
        logic     pinned;
        t_outcome res;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [S_DATA_W-1:0]   i_s_axis_tdata;
    logic [CMD_W-1:0]      i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [M_DATA_W-1:0]   o_m_axis_tdata;
    logic [STATUS_W-1:0]   o_m_axis_tuser;

    t_value   queue_slots [CAPACITY];
    int       queue_fill;
    t_outcome pending_results [$];
    t_outcome want;
    t_row     dir_rows [DIR_N];
    int       mismatches;
    int       items_accepted;
    int       burst_left;
    longint   cycle_cnt;
    logic     hold_off;
    int       sink_mode;
    int       sink_left;

    sorted_array_priority_queue_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ascending insert after equal entries, remove or read the head
    function automatic t_outcome queue_apply(t_cmd cmd, t_value value);
        t_outcome res;
        int       slot;
        res.status = ST_OK;
        res.data   = '0;
        case (cmd)
            CMD_ENQ: begin
                if (queue_fill >= CAPACITY) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    slot = queue_fill;
                    while (slot > 0 && queue_slots[slot-1] > value) begin
                        queue_slots[slot] = queue_slots[slot-1];
                        slot--;
                    end
                    queue_slots[slot] = value;
                    queue_fill++;
                end
            end
            CMD_DEQ, CMD_PEEK: begin
                if (queue_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data = queue_slots[0];
                    if (cmd == CMD_DEQ) begin
                        for (slot = 1; slot < queue_fill; slot++)
                            queue_slots[slot-1] = queue_slots[slot];
                        queue_fill--;
                    end
                end
            end
            default: ;
        endcase
        res.count = t_count'(queue_fill);
        return res;
    endfunction

    task automatic flag_mismatch(string field, longint want_v, longint got_v);
        if (mismatches < 10)
            $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
                     field, cycle_cnt, want_v, got_v);
        mismatches++;
    endtask

    task automatic offer_item(t_cmd cmd, t_value value, logic pinned, t_outcome pin_res);
        t_outcome res;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        i_s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        res = queue_apply(cmd, value);
        if (pinned)
            res = pin_res;
        pending_results.push_back(res);
        items_accepted++;
    endtask

    // bursts of random length, some long ones with no gaps at all
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("sorted_array_priority_queue_core regression: fail");
            $finish;
        end
    end

    // result checking and receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result, data", longint'(0),
                              longint'(o_m_axis_tdata[31:0]));
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tuser != want.status)
                    flag_mismatch("status", longint'(want.status),
                                  longint'(o_m_axis_tuser));
                if (t_value'(o_m_axis_tdata[31:0]) != want.data)
                    flag_mismatch("data", longint'(want.data),
                                  longint'(t_value'(o_m_axis_tdata[31:0])));
                if (o_m_axis_tdata[36:32] != want.count)
                    flag_mismatch("count", longint'(want.count),
                                  longint'(o_m_axis_tdata[36:32]));
                if (o_m_axis_tdata[39:37] != 3'b000)
                    flag_mismatch("padding", longint'(0),
                                  longint'(o_m_axis_tdata[39:37]));
            end
        end
        if (sink_left == 0) begin
            sink_mode = $urandom_range(0, 3);
            sink_left = $urandom_range(50, 200);
        end else begin
            sink_left--;
        end
        if (hold_off) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            case (sink_mode)
                0:       i_m_axis_tready <= 1'b1;
                1:       i_m_axis_tready <= 1'($urandom_range(0, 1));
                2:       i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: i_m_axis_tready <= (cycle_cnt[2:0] != 3'd0);
            endcase
        end
    end

    // long receiver hold-off so the core fills its output and stalls its input
    initial begin
        hold_off = 1'b0;
        wait (items_accepted >= 400);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        int       seg_left;
        int       enq_share;
        int       pick;
        t_cmd     cmd;
        t_value   value;
        t_outcome none;

        none            = '0;
        cycle_cnt       = 0;
        mismatches      = 0;
        items_accepted  = 0;
        burst_left      = 0;
        queue_fill      = 0;
        sink_mode       = 0;
        sink_left       = 0;
        seg_left        = 0;
        enq_share       = 40;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= CMD_ENQ;
        i_m_axis_tready <= 1'b0;

        dir_rows = '{
            '{CMD_DEQ,    32'sd0,           1'b1, '{ST_EMPTY, 32'sd0, 5'd0}},
            '{CMD_PEEK,   32'sd0,           1'b1, '{ST_EMPTY, 32'sd0, 5'd0}},
            '{CMD_UNUSED, -32'sd1,          1'b1, '{ST_OK, 32'sd0, 5'd0}},
            '{CMD_ENQ,    32'sd5,           1'b0, '0},
            '{CMD_ENQ,    32'sh7fffffff,    1'b0, '0},
            '{CMD_ENQ,    32'sh80000000,    1'b0, '0},
            '{CMD_ENQ,    32'sd0,           1'b0, '0},
            '{CMD_ENQ,    -32'sd1,          1'b0, '0},
            '{CMD_ENQ,    32'sd5,           1'b0, '0},
            '{CMD_ENQ,    32'sd1,           1'b0, '0},
            '{CMD_ENQ,    -32'sd7,          1'b0, '0},
            '{CMD_ENQ,    32'sh7fffffff,    1'b0, '0},
            '{CMD_ENQ,    32'sh80000000,    1'b0, '0},
            '{CMD_ENQ,    32'sd1000,        1'b0, '0},
            '{CMD_ENQ,    -32'sd1000,       1'b0, '0},
            '{CMD_ENQ,    32'sd3,           1'b0, '0},
            '{CMD_ENQ,    32'sd5,           1'b0, '0},
            '{CMD_ENQ,    32'sh55555555,    1'b0, '0},
            '{CMD_ENQ,    32'shaaaaaaaa,    1'b0, '0},
            '{CMD_ENQ,    32'sd42,          1'b1, '{ST_OVERFLOW, 32'sd0, 5'd16}},
            '{CMD_UNUSED, 32'sh7fffffff,    1'b1, '{ST_OK, 32'sd0, 5'd16}},
            '{CMD_PEEK,   32'sd0,           1'b0, '0},
            '{CMD_DEQ,    32'sd0,           1'b0, '0},
            '{CMD_DEQ,    32'sd0,           1'b0, '0}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            offer_item(dir_rows[r].cmd, dir_rows[r].value, dir_rows[r].pinned,
                       dir_rows[r].res);
            pace_sender();
        end

        // segments lean toward filling, balancing or draining the queue
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (seg_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       enq_share = 70;
                    1:       enq_share = 42;
                    default: enq_share = 15;
                endcase
                seg_left = $urandom_range(20, 80);
            end
            seg_left--;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                cmd = CMD_UNUSED;
            else if (pick < 15)
                cmd = CMD_PEEK;
            else if (pick < 15 + enq_share)
                cmd = CMD_ENQ;
            else
                cmd = CMD_DEQ;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: value = $urandom;
                5, 6, 7:       value = $signed($urandom_range(0, 16)) - 8;
                default: begin
                    case ($urandom_range(0, 3))
                        0:       value = 32'sh80000000;
                        1:       value = 32'sh7fffffff;
                        2:       value = 32'sd0;
                        default: value = -32'sd1;
                    endcase
                end
            endcase
            offer_item(cmd, value, 1'b0, none);
            pace_sender();
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("sorted_array_priority_queue_core regression: pass");
        end else begin
            $display("sorted_array_priority_queue_core regression: fail");
        end
        $finish;
    end

endmodule
